// File: hw/rtl/fhr_pkg.sv
// Shared types, constants and codes for the filter history ring bank.
package fhr_pkg;

    localparam int DEFAULT_BANK_DEPTH = 8;
    localparam int DEFAULT_ENTRY_BITS = 64;

    localparam int FIELD_BITS = 64;
    localparam int OP_BITS    = 2;
    localparam int AGE_BITS   = 3;
    localparam int FILL_BITS  = 4;

    // Config port: 64-bit registers at 8-byte spacing.
    localparam int PADDR_BITS   = 4;
    localparam int PDATA_BITS   = 64;
    localparam int REG_OFS_BITS = 3;
    localparam int REG_IDX_BITS = PADDR_BITS - REG_OFS_BITS;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_DEFAULT_ENTRY = 1'b0
    } t_reg_idx;

    typedef enum logic [OP_BITS-1:0] {
        OP_RESET  = 2'd0,
        OP_ADD    = 2'd1,
        OP_READ   = 2'd2,
        OP_UPDATE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                   operation;
        logic [AGE_BITS-1:0]   age_index;
        logic [FIELD_BITS-1:0] entry_in;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0] entry_out;
        logic [FILL_BITS-1:0]  fill_count;
        logic                  age_error;
    } t_out_item;

endpackage

// File: hw/rtl/fhr_cfg.sv
// Configuration register block: holds the default entry behind an APB-style port.
module fhr_cfg #(
    parameter int ENTRY_BITS = fhr_pkg::DEFAULT_ENTRY_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fhr_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [fhr_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [fhr_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready,
    output logic [ENTRY_BITS-1:0]           o_default_entry
);
    import fhr_pkg::*;

    logic [ENTRY_BITS-1:0]   r_default;
    logic [REG_IDX_BITS-1:0] w_idx;
    logic                    w_hit;
    logic                    w_write;

    assign w_idx   = paddr[PADDR_BITS-1:REG_OFS_BITS];
    assign w_hit   = (w_idx == REG_DEFAULT_ENTRY);
    assign w_write = psel && penable && pwrite && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= '0;
        end else if (w_write) begin
            r_default <= pwdata[ENTRY_BITS-1:0];
        end
    end

    assign pready          = 1'b1;
    assign prdata          = w_hit ? PDATA_BITS'(r_default) : '0;
    assign o_default_entry = r_default;

endmodule

// File: hw/rtl/fhr_bank.sv
// Slot array, newest pointer and fill count, with the per-operation update logic.
module fhr_bank #(
    parameter int BANK_DEPTH = fhr_pkg::DEFAULT_BANK_DEPTH,
    parameter int ENTRY_BITS = fhr_pkg::DEFAULT_ENTRY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_exec,
    input  fhr_pkg::t_in_item     i_item,
    input  logic [ENTRY_BITS-1:0] i_default_entry,
    output fhr_pkg::t_out_item    o_result
);
    import fhr_pkg::*;

    localparam int SLOT_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BANK_DEPTH + 1);
    localparam int DIFF_W = SLOT_W + AGE_BITS + 1;

    logic [ENTRY_BITS-1:0] r_slots [BANK_DEPTH];
    logic [SLOT_W-1:0]     r_newest;
    logic [CNT_W-1:0]      r_count;

    logic [SLOT_W-1:0]     n_newest;
    logic [CNT_W-1:0]      n_count;

    logic                  w_empty;
    logic                  w_full;
    logic                  w_err;
    logic [DIFF_W-1:0]     w_newest_x;
    logic [DIFF_W-1:0]     w_age_x;
    logic [DIFF_W-1:0]     w_diff;
    logic [SLOT_W-1:0]     w_age_slot;
    logic [SLOT_W-1:0]     w_add_slot;
    logic                  w_wr_en;
    logic [SLOT_W-1:0]     w_wr_addr;
    logic [ENTRY_BITS-1:0] w_wr_data;
    logic [ENTRY_BITS-1:0] w_entry;
    logic [ENTRY_BITS-1:0] w_rd_data;

    assign w_entry = i_item.entry_in[ENTRY_BITS-1:0];
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(BANK_DEPTH));
    assign w_err   = !w_empty && (32'(i_item.age_index) >= 32'(r_count));

    // Age 0 is the newest slot; step back with wraparound.
    assign w_newest_x = DIFF_W'(r_newest);
    assign w_age_x    = DIFF_W'(i_item.age_index);
    assign w_diff     = (w_newest_x < w_age_x)
                        ? (w_newest_x + DIFF_W'(BANK_DEPTH) - w_age_x)
                        : (w_newest_x - w_age_x);
    assign w_age_slot = w_empty ? '0 : w_diff[SLOT_W-1:0];

    assign w_add_slot = !w_full ? r_count[SLOT_W-1:0]
                      : (r_newest == SLOT_W'(BANK_DEPTH - 1)) ? '0
                      : SLOT_W'(r_newest + 1'b1);

    assign w_rd_data = r_slots[w_age_slot];

    always_comb begin
        n_newest  = r_newest;
        n_count   = r_count;
        w_wr_en   = 1'b0;
        w_wr_addr = w_age_slot;
        w_wr_data = w_entry;
        o_result  = '0;
        case (i_item.operation)
            OP_RESET: begin
                n_newest  = '0;
                n_count   = '0;
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
                w_wr_data = i_default_entry;
            end
            OP_ADD: begin
                n_newest  = w_add_slot;
                n_count   = w_full ? r_count : CNT_W'(r_count + 1'b1);
                w_wr_en   = 1'b1;
                w_wr_addr = w_add_slot;
            end
            OP_READ: begin
                o_result.age_error = w_err;
                if (!w_err) begin
                    o_result.entry_out = FIELD_BITS'(w_rd_data);
                end
            end
            OP_UPDATE: begin
                o_result.age_error = w_err;
                w_wr_en            = !w_err;
            end
            default: begin
                n_newest = r_newest;
            end
        endcase
        // Count wraps to four bits at full depth 16.
        o_result.fill_count = FILL_BITS'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_count  <= '0;
        end else if (i_exec) begin
            r_newest <= n_newest;
            r_count  <= n_count;
        end
    end

    // Only slot 0 has a reset value; the rest are read only after an add.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots[0] <= '0;
        end else if (i_exec && w_wr_en) begin
            r_slots[w_wr_addr] <= w_wr_data;
        end
    end

endmodule

// File: hw/rtl/filter_history_ring_bank_core.sv
// Top level of the filter history ring bank: input register, bank, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one operation per
//   transaction: reset, add newest, read by age, or update by age. Output channel
//   (o_out_valid / i_out_stall / o_out_item) returns exactly one result transaction
//   per input transaction, in order: the read entry, the fill count after the
//   operation, and an age error flag.
//   Path: input register, bank logic, result register, then the output channel.
//   Throughput: one transaction per cycle without receiver stalls, set by the single
//   pass through the bank logic between the input register and the result register.
//   Stall: when the receiver stalls while a result waits, the result register
//   holds, the input register holds its transaction, and o_in_stall rises
//   once the input register is occupied.
//   Reset (i_rst_n low, synchronous): both channels empty, the bank empty with
//   slot 0 cleared to zero, the default entry register cleared.
//   Configuration: the default entry is written through the APB-style port at
//   byte address 0; users must do so only with no transaction in flight (not enforced).
module filter_history_ring_bank_core #(
    parameter int BANK_DEPTH = fhr_pkg::DEFAULT_BANK_DEPTH,
    parameter int ENTRY_BITS = fhr_pkg::DEFAULT_ENTRY_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fhr_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fhr_pkg::t_out_item              o_out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fhr_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [fhr_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [fhr_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready
);
    import fhr_pkg::*;

    logic                  r_in_valid;
    t_in_item              r_in_item;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  w_advance;
    logic                  w_exec;
    logic                  w_in_accept;
    t_out_item             w_result;
    logic [ENTRY_BITS-1:0] w_default_entry;

    // Advance the bank stage when the result register is free or being drained.
    assign w_advance   = !r_out_valid || !i_out_stall;
    assign w_exec      = r_in_valid && w_advance;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    fhr_cfg #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_default_entry (w_default_entry)
    );

    fhr_bank #(
        .BANK_DEPTH (BANK_DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_bank (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_exec          (w_exec),
        .i_item          (r_in_item),
        .i_default_entry (w_default_entry),
        .o_result        (w_result)
    );

    // Input register: load a new transaction whenever the slot is free or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register: hold while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: tb/sv/fhr_result_checker.sv
// Result checker for the filter history ring bank: bank prediction and in-order compare.
`timescale 1ns / 1ps

module fhr_result_checker #(
    parameter int BANK_DEPTH = fhr_pkg::DEFAULT_BANK_DEPTH,
    parameter int ENTRY_BITS = fhr_pkg::DEFAULT_ENTRY_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  fhr_pkg::t_in_item              i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  fhr_pkg::t_out_item             i_out_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fhr_pkg::PADDR_BITS-1:0] paddr,
    input  logic [fhr_pkg::PDATA_BITS-1:0] pwdata,
    input  logic                           pready,
    output int                             o_fail_count,
    output int                             o_pending
);
    import fhr_pkg::*;

    localparam logic [FIELD_BITS-1:0] ENTRY_MASK =
        {FIELD_BITS{1'b1}} >> (FIELD_BITS - ENTRY_BITS);

    logic [FIELD_BITS-1:0] bank_slots [BANK_DEPTH];
    logic [FIELD_BITS-1:0] default_word;
    int                    newest_idx;
    int                    live_count;
    t_out_item             results_due [$];
    t_out_item             want;
    int                    fails;

    // Apply one transaction to the shadow bank and return its result.
    function automatic t_out_item bank_apply(t_in_item it);
        t_out_item r;
        int        slot;
        logic [FIELD_BITS-1:0] word;
        r    = '0;
        slot = 0;
        word = it.entry_in & ENTRY_MASK;
        case (it.operation)
            OP_RESET: begin
                bank_slots[0] = default_word;
                live_count    = 0;
                newest_idx    = 0;
            end
            OP_ADD: begin
                if (live_count < BANK_DEPTH) begin
                    newest_idx = live_count;
                    live_count++;
                end else begin
                    newest_idx = (newest_idx + 1) % BANK_DEPTH;
                end
                bank_slots[newest_idx] = word;
            end
            default: begin
                // empty bank: any age lands on slot 0 without error
                if (live_count != 0) begin
                    if (int'(it.age_index) >= live_count)
                        r.age_error = 1'b1;
                    else
                        slot = (newest_idx + BANK_DEPTH - int'(it.age_index)) % BANK_DEPTH;
                end
                if (!r.age_error) begin
                    if (it.operation == OP_READ)
                        r.entry_out = bank_slots[slot] & ENTRY_MASK;
                    else
                        bank_slots[slot] = word;
                end
            end
        endcase
        r.fill_count = FILL_BITS'(live_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bank_slots[0] = '0;
            default_word  = '0;
            newest_idx    = 0;
            live_count    = 0;
            fails         = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: unexpected result entry %h fill %0d err %b", $realtime,
                                 i_out_item.entry_out, i_out_item.fill_count,
                                 i_out_item.age_error);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (want.entry_out !== i_out_item.entry_out ||
                        want.fill_count !== i_out_item.fill_count ||
                        want.age_error !== i_out_item.age_error) begin
                        if (fails < 10)
                            $display({"%0t: mismatch exp entry %h fill %0d err %b,",
                                      " got entry %h fill %0d err %b"},
                                     $realtime, want.entry_out, want.fill_count,
                                     want.age_error, i_out_item.entry_out,
                                     i_out_item.fill_count, i_out_item.age_error);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(bank_apply(i_in_item));
            if (psel && penable && pwrite && pready &&
                paddr[PADDR_BITS-1:REG_OFS_BITS] == REG_DEFAULT_ENTRY)
                default_word = pwdata & ENTRY_MASK;
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

// File: tb/sv/filter_history_ring_bank_core_tb.sv
// Top of the filter history ring bank testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module filter_history_ring_bank_core_tb;
    import fhr_pkg::*;

    localparam int                    RUN_LIMIT   = 400000;
    localparam int                    PHASES      = 6;
    localparam int                    PHASE_ITEMS = 150;
    localparam int                    LONG_HOLD   = 100;
    localparam logic [FIELD_BITS-1:0] ALL_ONES    = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int cycles;
    // The sender raises a request, the receiver answers with one long hold.
    int hold_reqs;
    int holds_done;

    filter_history_ring_bank_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    fhr_result_checker result_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stop a hung run; a correct run stays far below the limit.
    initial begin
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL filter_history_ring_bank_core");
        $finish;
    end

    // Offer one transaction and hold it until accepted, then drop valid and idle for the gap.
    // Valid stays high across back-to-back transactions when gap is zero.
    task automatic send_op(input t_op op, input int age, input logic [FIELD_BITS-1:0] word,
                           input int gap);
        t_in_item it;
        it.operation = op;
        it.age_index = AGE_BITS'(age);
        it.entry_in  = word;
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Setup cycle, then access cycle; the register takes the data at the access edge.
    task automatic write_default_entry(input logic [PDATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DEFAULT_ENTRY, {REG_OFS_BITS{1'b0}}};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait for every outstanding result, with a margin after the last.
    task automatic drain;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_word;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    // Receiver: segments of no stall, dense stall, or rare long stalls;
    // a pending hold request preempts the current segment.
    initial begin
        int mode;
        int seg;
        holds_done  = 0;
        i_out_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_reqs != holds_done) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else begin
                mode = $urandom_range(0, 2);
                seg  = $urandom_range(20, 150);
                for (int c = 0; c < seg; c++) begin
                    if (hold_reqs != holds_done)
                        break;
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 99) < 35);
                        default: begin
                            if ($urandom_range(0, 39) == 0) begin
                                i_out_stall <= 1'b1;
                                repeat ($urandom_range(10, 30)) @(posedge i_clk);
                            end
                            i_out_stall <= 1'b0;
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [PDATA_BITS-1:0] cfg_vals [PHASES];
        int                    r;
        t_op                   op;

        hold_reqs   = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_default_entry(64'hDEAD_BEEF_0123_4567);
        drain();

        // Directed: empty-bank access, reset op, fill and wrap, age errors.
        send_op(OP_READ,   0, '0, pick_gap(0));                    // empty, slot 0 after reset
        send_op(OP_READ,   7, ALL_ONES, pick_gap(0));              // empty, largest age
        // empty update hits slot 0
        send_op(OP_UPDATE, 5, 64'hA5A5_5A5A_0F0F_F0F0, pick_gap(0));
        send_op(OP_READ,   3, '0, pick_gap(0));
        send_op(OP_RESET,  0, ALL_ONES, pick_gap(0));              // loads default entry
        send_op(OP_READ,   0, '0, pick_gap(0));
        for (int k = 0; k < 9; k++)                                // nine adds wrap the ring
            send_op(OP_ADD, 0, (k == 0) ? '0 : (k == 1) ? ALL_ONES : {$urandom, $urandom},
                    pick_gap(0));
        send_op(OP_READ,   0, '0, pick_gap(0));
        send_op(OP_READ,   7, '0, pick_gap(0));                    // oldest after wrap
        send_op(OP_UPDATE, 7, 64'h8000_0000_0000_0001, pick_gap(0));
        send_op(OP_READ,   7, '0, pick_gap(0));
        send_op(OP_RESET,  2, '0, pick_gap(0));
        send_op(OP_ADD,    0, 64'h0123_4567_89AB_CDEF, pick_gap(0));
        send_op(OP_READ,   1, '0, pick_gap(0));                    // age beyond fill count
        send_op(OP_UPDATE, 7, ALL_ONES, pick_gap(0));              // ignored on age error
        send_op(OP_READ,   0, '0, 0);

        cfg_vals[0] = '0;
        cfg_vals[1] = ALL_ONES;
        cfg_vals[2] = {$urandom, $urandom};
        cfg_vals[3] = 64'h8000_0000_0000_0001;
        cfg_vals[4] = {$urandom, $urandom};
        cfg_vals[5] = 64'h5555_5555_AAAA_AAAA;

        // Random phases, each under its own default entry. Adds are the most frequent
        // operation, so the bank often fills and wraps; resets keep small fills.
        for (int ph = 0; ph < PHASES; ph++) begin
            i_in_valid <= 1'b0;
            drain();
            write_default_entry(cfg_vals[ph]);
            if (ph == 1 || ph == 4)
                hold_reqs++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    op = OP_RESET;
                else if (r < 40)
                    op = OP_ADD;
                else if (r < 72)
                    op = OP_READ;
                else
                    op = OP_UPDATE;
                // keep offering while the receiver holds off, so the input backs up
                send_op(op, $urandom_range(0, 7), pick_word(),
                        (hold_reqs != holds_done) ? 0 : pick_gap(ph == 2));
            end
        end
        i_in_valid <= 1'b0;
        drain();
        repeat (5) @(posedge i_clk);

        if (fail_count == 0)
            $display("PASS filter_history_ring_bank_core");
        else
            $display("FAIL filter_history_ring_bank_core");
        $finish;
    end

endmodule
